### rtl/cdq_pkg.sv
package cdq_pkg;

	// Fixed field widths
	localparam int FUNC_W = 3;
	localparam int CFG_W  = 5;
	localparam int OUT_W  = 32;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_DEPTH  = 16;
	localparam int DEF_DATA_WIDTH = 32;

	// Capacity after reset, before clamping to the ring depth
	localparam int CAP_RESET = 16;

	// Operation codes; the unused codes act as a query
	localparam logic [FUNC_W-1:0] F_INS_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] F_INS_REAR  = 3'd1;
	localparam logic [FUNC_W-1:0] F_DEL_FRONT = 3'd2;
	localparam logic [FUNC_W-1:0] F_DEL_REAR  = 3'd3;
	localparam logic [FUNC_W-1:0] F_QUERY     = 3'd4;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic read;
	} cmd_t;

endpackage

### rtl/cdq_ram.sv
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Register both read ports
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

### rtl/cdq_ctrl.sv
module cdq_ctrl
	import cdq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	// Take a new item while idle or while the last result is shown
	assign busy   = (state_q == ST_EXEC) || (state_q == ST_READ);
	assign accept = start && !busy;
	assign done   = (state_q == ST_RESP);

	assign cmd.capture = accept;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.read    = (state_q == ST_READ);

	// Advance through update, read and response
	always_comb begin
		unique case (state_q)
			ST_IDLE: state_d = accept ? ST_EXEC : ST_IDLE;
			ST_EXEC: state_d = ST_READ;
			ST_READ: state_d = ST_RESP;
			ST_RESP: state_d = accept ? ST_EXEC : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/cdq_dpath.sv
module cdq_dpath
	import cdq_pkg::*;
#(
	parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [FUNC_W-1:0]  func,
	input  logic signed [31:0] data_value,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_data,
	output logic               ok,
	output logic signed [31:0] front_value,
	output logic signed [31:0] rear_value,
	output logic               is_empty,
	output logic               is_full
);

	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CAP_W = IDX_W + 1;
	localparam int CAP_RST_I = (CAP_RESET > MAX_DEPTH) ? MAX_DEPTH : CAP_RESET;
	localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(CAP_RST_I);
	localparam logic [DATA_WIDTH-1:0] EMPTY_WORD = '1;
	localparam logic [OUT_W-1:0] EMPTY_OUT = OUT_W'(64'(EMPTY_WORD));

	function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i,
	                                               input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] s;
		s = CAP_W'(i) + CAP_W'(1);
		return (s >= cap) ? '0 : s[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] i,
	                                               input logic [CAP_W-1:0] cap);
		return (i == '0) ? IDX_W'(cap - CAP_W'(1)) : i - IDX_W'(1);
	endfunction

	logic [FUNC_W-1:0]     func_q;
	logic [31:0]           data_q;
	logic [IDX_W-1:0]      head_q, tail_q;
	logic [IDX_W-1:0]      head_d, tail_d;
	logic                  empty_q, empty_d;
	logic [CAP_W-1:0]      cap_q;
	logic [CAP_W-1:0]      cap_d;
	logic                  ok_q, ok_d;
	logic                  full;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [DATA_WIDTH-1:0] rd_front, rd_rear;
	logic [31:0]           cfg_wide;
	logic [63:0]           data_wide;

	// Clamp the written capacity to 1..MAX_DEPTH
	always_comb begin
		cfg_wide = (cfg_data == '0) ? 32'd1 : 32'(cfg_data);
		if (cfg_wide > 32'(MAX_DEPTH)) begin
			cfg_wide = 32'(MAX_DEPTH);
		end
		cap_d = CAP_W'(cfg_wide);
	end

	assign full = !empty_q && (head_q == slot_next(tail_q, cap_q));

	// Store the low DATA_WIDTH bits of the inserted value
	assign data_wide = {32'b0, data_q};
	assign wdata     = data_wide[DATA_WIDTH-1:0];

	// Work out the new indices, flag and store write
	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		empty_d = empty_q;
		ok_d    = 1'b1;
		we      = 1'b0;
		waddr   = '0;
		unique case (func_q)
			F_INS_FRONT, F_INS_REAR: begin
				if (full) begin
					ok_d = 1'b0;
				end else if (empty_q) begin
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b0;
					we      = 1'b1;
				end else if (func_q == F_INS_FRONT) begin
					head_d = slot_prev(head_q, cap_q);
					waddr  = head_d;
					we     = 1'b1;
				end else begin
					tail_d = slot_next(tail_q, cap_q);
					waddr  = tail_d;
					we     = 1'b1;
				end
			end
			F_DEL_FRONT, F_DEL_REAR: begin
				if (empty_q) begin
					ok_d = 1'b0;
				end else if (head_q == tail_q) begin
					empty_d = 1'b1;
				end else if (func_q == F_DEL_FRONT) begin
					head_d = slot_next(head_q, cap_q);
				end else begin
					tail_d = slot_prev(tail_q, cap_q);
				end
			end
			default: begin
				ok_d = 1'b1;
			end
		endcase
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			data_q <= data_value;
		end
	end

	// Update ring state; a capacity write empties the deque
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			cap_q   <= CAP_RST;
			ok_q    <= 1'b0;
		end else if (cfg_we) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			cap_q   <= cap_d;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
			ok_q    <= ok_d;
		end
	end

	cdq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (cmd.exec && we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (cmd.read),
		.raddr_a (head_q),
		.raddr_b (tail_q),
		.rdata_a (rd_front),
		.rdata_b (rd_rear)
	);

	// Drive the result from registered state and read data
	assign ok          = ok_q;
	assign is_empty    = empty_q;
	assign is_full     = full;
	assign front_value = $signed(empty_q ? EMPTY_OUT : OUT_W'(64'(rd_front)));
	assign rear_value  = $signed(empty_q ? EMPTY_OUT : OUT_W'(64'(rd_rear)));

endmodule

### rtl/circular_deque.sv
// Channel   | Signals                                  | Transfer
// ----------+------------------------------------------+------------------------------
// item in   | start, busy, func, data_value            | start high, busy low
// result    | done, ok, front_value, rear_value,       | done high, one cycle only
//           | is_empty, is_full                        |
// config    | cfg_valid, cfg_ready, cfg_data           | cfg_valid and cfg_ready high
//
// An item passes through index update and store write, a two-port
// store read, then the result on the ports. The next item can be taken
// while the result is shown, but not during the update or the read.
// Reset empties the deque and sets capacity to 16, clamped to MAX_DEPTH.
// The result is shown for exactly one cycle; the receiver cannot hold it.
module circular_deque
	import cdq_pkg::*;
#(
	parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [FUNC_W-1:0]  func,
	input  logic signed [31:0] data_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data,
	output logic               done,
	output logic               ok,
	output logic signed [31:0] front_value,
	output logic signed [31:0] rear_value,
	output logic               is_empty,
	output logic               is_full
);

	cmd_t cmd;

	// Accept configuration whenever no item is in flight
	assign cfg_ready = !busy;

	cdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	cdq_dpath #(
		.MAX_DEPTH  (MAX_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (func),
		.data_value  (data_value),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.ok          (ok),
		.front_value (front_value),
		.rear_value  (rear_value),
		.is_empty    (is_empty),
		.is_full     (is_full)
	);

endmodule

### rtl/cdq_checker.sv
module cdq_checker
	import cdq_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] front_value,
	input logic signed [31:0] rear_value,
	input logic               is_empty,
	input logic               is_full
);

	// Each transfer yields its result after the update and read states
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result did not follow an accepted item");

	// Go busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("not busy after accepting an item");

	// Never show two results back to back
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// Empty deque reports the same fill value at both ends
	a_empty_val: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_empty |-> front_value == rear_value)
		else $error("empty deque shows differing end values");

	// Empty and full never hold together
	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_empty && is_full))
		else $error("deque reported empty and full");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.front_value (front_value),
	.rear_value  (rear_value),
	.is_empty    (is_empty),
	.is_full     (is_full)
);
